// ===== rtl/core/cfs_pkg.sv =====
// Package for the color fade sequencer: sizes, the color and step entry types,
// and the phase and operation codes. Used by every module under rtl/core.
// No dependencies.
package cfs_pkg;

	localparam int MAX_STEPS = 16;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int CNT_W     = 5;
	localparam int TIME_W    = 32;
	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 3;
	// Quotient of one channel step is below 2**CHAN_W because elapsed < transit.
	localparam int PROD_W    = TIME_W + CHAN_W;

	// Request operation codes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

	typedef struct packed {
		rgb_t              start_color;
		rgb_t              end_color;
		logic [TIME_W-1:0] transit;
		logic [TIME_W-1:0] hold;
	} step_entry_t;

	typedef enum logic [1:0] {
		PH_LOAD    = 2'd0,
		PH_TRANSIT = 2'd1,
		PH_HOLD    = 2'd2
	} phase_t;

endpackage

// ===== rtl/core/cfs_step_table.sv =====
// Step table of the color fade sequencer: one write port, one registered read port.
// Depends on cfs_pkg.
module cfs_step_table (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [cfs_pkg::IDX_W-1:0] wr_addr,
	input  cfs_pkg::step_entry_t      wr_data,
	input  logic                      rd_en,
	input  logic [cfs_pkg::IDX_W-1:0] rd_addr,
	output cfs_pkg::step_entry_t      rd_data
);
	import cfs_pkg::*;

	step_entry_t mem_q [MAX_STEPS];
	step_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/cfs_lerp_div.sv =====
// Shared fade unit: multiplies elapsed time by a channel difference magnitude,
// then divides by the transit time one quotient bit per cycle. Depends on cfs_pkg.
module cfs_lerp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cfs_pkg::TIME_W-1:0] elapsed,
	input  logic [cfs_pkg::CHAN_W-1:0] mag,
	input  logic [cfs_pkg::TIME_W-1:0] span,
	output logic                       busy,
	output logic                       done,
	output logic [cfs_pkg::CHAN_W-1:0] quo
);
	import cfs_pkg::*;

	localparam int STEP_W = $clog2(CHAN_W);

	typedef enum logic [1:0] {
		D_IDLE,
		D_MUL,
		D_DIV
	} div_state_t;

	div_state_t        state_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [TIME_W-1:0] span_q;
	logic [TIME_W-1:0] rem_q;
	logic [CHAN_W-1:0] lo_q;
	logic [CHAN_W-1:0] quo_q;

	logic [TIME_W:0]   trial;
	logic              fits;
	logic [TIME_W:0]   diff;

	// The remainder always stays below the divisor, so one subtract per step suffices.
	assign trial = {rem_q, lo_q[CHAN_W-1]};
	assign fits  = trial >= {1'b0, span_q};
	assign diff  = trial - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						prod_q  <= {{(PROD_W-TIME_W){1'b0}}, elapsed} *
						           {{(PROD_W-CHAN_W){1'b0}}, mag};
						span_q  <= span;
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					rem_q   <= prod_q[PROD_W-1:CHAN_W];
					lo_q    <= prod_q[CHAN_W-1:0];
					cnt_q   <= '0;
					state_q <= D_DIV;
				end
				D_DIV: begin
					rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
					lo_q  <= {lo_q[CHAN_W-2:0], 1'b0};
					quo_q <= {quo_q[CHAN_W-2:0], fits};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(CHAN_W-1)) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign busy = (state_q != D_IDLE);
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/color_fade_sequencer.sv =====
// Color fade sequencer top level: request and result channels, step count register,
// phase sequencer. Depends on cfs_pkg, cfs_step_table and cfs_lerp_div.
//
// Usage: a request with operation high writes one step table entry; a request with
// operation low is a millisecond tick that advances the load, transit and hold phases.
// Every request returns exactly one result with the current color and the phase.
// The step count register is written through cfg_wr_en and cfg_wr_data by the user,
// only while idle; the block itself does not enforce it. A count of zero halts
// sequencing. Entries must be written before they are used. A table write goes
// straight to its result; a tick first evaluates the phase, and a load also fetches
// the step table entry. A tick that interpolates runs the single shared multiply and
// divide unit on the three color channels in turn; for each channel the unit
// multiplies, sets up the division, forms eight quotient bits and hands them back.
// One request is in work at a time: in_stall stays high from acceptance until the
// result is placed in the output register, so no new request is taken before then.
// A result may still wait there under out_stall while the next request is accepted;
// the block then holds before delivering until the register frees up.
// Reset clears the phase (load), step pointer, start, transit and hold times, working
// colors (black) and step count. The step table itself is not cleared.
module color_fade_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [cfs_pkg::CNT_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [cfs_pkg::TIME_W-1:0] time_now,
	input  logic [cfs_pkg::IDX_W-1:0]  entry_index,
	input  logic [cfs_pkg::CHAN_W-1:0] start_red,
	input  logic [cfs_pkg::CHAN_W-1:0] start_green,
	input  logic [cfs_pkg::CHAN_W-1:0] start_blue,
	input  logic [cfs_pkg::CHAN_W-1:0] end_red,
	input  logic [cfs_pkg::CHAN_W-1:0] end_green,
	input  logic [cfs_pkg::CHAN_W-1:0] end_blue,
	input  logic [cfs_pkg::TIME_W-1:0] transit_ms,
	input  logic [cfs_pkg::TIME_W-1:0] hold_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cfs_pkg::CHAN_W-1:0] red,
	output logic [cfs_pkg::CHAN_W-1:0] green,
	output logic [cfs_pkg::CHAN_W-1:0] blue,
	output logic [1:0]                 phase
);
	import cfs_pkg::*;

	localparam int CH_IDX_W = $clog2(NUM_CHAN);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FETCH,
		ST_CHAN_START,
		ST_CHAN_WAIT,
		ST_FINISH
	} seq_state_t;

	seq_state_t          state_q;
	phase_t              phase_q;
	logic [CNT_W-1:0]    step_count_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [TIME_W-1:0]   time_q;
	logic [TIME_W-1:0]   start_time_q;
	logic [TIME_W-1:0]   elapsed_q;
	rgb_t                act_start_q;
	rgb_t                act_end_q;
	rgb_t                cur_q;
	logic [TIME_W-1:0]   act_transit_q;
	logic [TIME_W-1:0]   act_hold_q;
	logic [CH_IDX_W-1:0] chan_q;
	logic                out_valid_q;
	rgb_t                out_color_q;
	logic [1:0]          out_phase_q;

	logic                accept;
	logic [CNT_W-1:0]    count;
	logic [CNT_W-1:0]    ptr_wrap;
	logic [TIME_W-1:0]   elapsed;
	step_entry_t         wr_entry;
	step_entry_t         rd_entry;
	logic                rd_en;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [CHAN_W-1:0]   div_quo;
	logic [CHAN_W-1:0]   ch_a;
	logic [CHAN_W-1:0]   ch_b;
	logic                ch_neg;
	logic [CHAN_W-1:0]   ch_mag;
	logic                out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign count    = (step_count_q > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : step_count_q;
	assign ptr_wrap = (ptr_q >= count) ? '0 : ptr_q;
	assign elapsed  = time_q - start_time_q;

	assign wr_entry.start_color = {start_blue, start_green, start_red};
	assign wr_entry.end_color   = {end_blue, end_green, end_red};
	assign wr_entry.transit     = transit_ms;
	assign wr_entry.hold        = hold_ms;

	// The table read is issued while evaluating the load phase with a nonzero count.
	assign rd_en = (state_q == ST_EVAL) && (phase_q == PH_LOAD) && (count != '0);

	cfs_step_table u_table (
		.clk     (clk),
		.wr_en   (accept && (operation == OP_WRITE)),
		.wr_addr (entry_index),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (ptr_wrap[IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	assign ch_a      = act_start_q[chan_q];
	assign ch_b      = act_end_q[chan_q];
	assign ch_neg    = ch_b < ch_a;
	assign ch_mag    = ch_neg ? (ch_a - ch_b) : (ch_b - ch_a);
	assign div_start = (state_q == ST_CHAN_START);

	cfs_lerp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.elapsed (elapsed_q),
		.mag     (ch_mag),
		.span    (act_transit_q),
		.busy    (div_busy),
		.done    (div_done),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_LOAD;
			step_count_q  <= '0;
			ptr_q         <= '0;
			start_time_q  <= '0;
			act_start_q   <= '0;
			act_end_q     <= '0;
			cur_q         <= '0;
			act_transit_q <= '0;
			act_hold_q    <= '0;
			chan_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				step_count_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						time_q  <= time_now;
						state_q <= (operation == OP_WRITE) ? ST_FINISH : ST_EVAL;
					end
				end
				ST_EVAL: begin
					elapsed_q <= elapsed;
					state_q   <= ST_FINISH;
					case (phase_q)
						PH_LOAD: begin
							ptr_q <= ptr_wrap;
							if (count != '0) begin
								state_q <= ST_FETCH;
							end
						end
						PH_TRANSIT: begin
							if (elapsed >= act_transit_q) begin
								phase_q      <= PH_HOLD;
								start_time_q <= time_q;
								cur_q        <= act_end_q;
							end else begin
								chan_q  <= '0;
								state_q <= ST_CHAN_START;
							end
						end
						PH_HOLD: begin
							if (elapsed > act_hold_q) begin
								phase_q <= PH_LOAD;
							end
						end
						default: ;
					endcase
				end
				ST_FETCH: begin
					act_start_q   <= rd_entry.start_color;
					act_end_q     <= rd_entry.end_color;
					cur_q         <= rd_entry.start_color;
					act_transit_q <= rd_entry.transit;
					act_hold_q    <= rd_entry.hold;
					start_time_q  <= time_q;
					ptr_q         <= ptr_q + 1'b1;
					phase_q       <= PH_TRANSIT;
					state_q       <= ST_FINISH;
				end
				ST_CHAN_START: begin
					state_q <= ST_CHAN_WAIT;
				end
				ST_CHAN_WAIT: begin
					if (div_done) begin
						cur_q[chan_q] <= ch_neg ? (ch_a - div_quo) : (ch_a + div_quo);
						if (chan_q == CH_IDX_W'(NUM_CHAN-1)) begin
							state_q <= ST_FINISH;
						end else begin
							chan_q  <= chan_q + 1'b1;
							state_q <= ST_CHAN_START;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_color_q <= cur_q;
						out_phase_q <= phase_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_color_q[0];
	assign green     = out_color_q[1];
	assign blue      = out_color_q[2];
	assign phase     = out_phase_q;

`ifndef SYNTH
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("fade unit started while still busy");

	a_load_advances_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		($past(phase_q) == PH_LOAD && phase_q == PH_TRANSIT) |->
		(ptr_q != '0 && ptr_q <= CNT_W'(MAX_STEPS)))
		else $error("step pointer out of range after a load");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result delivered outside the finish step");
`endif

endmodule
